### rtl/core/wes_pkg.sv
`timescale 1ns / 1ps

package wes_pkg;

    // width of the window half-size register, fixed by the register map
    localparam int WIN_W = 31;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_MAX  = 2'd1,
        MODE_MIN  = 2'd2
    } snap_mode_t;

    // per-sample control handed from the window check to the tracker
    typedef struct packed {
        logic step;       // a sample is processed this cycle
        logic in_window;  // finite depth within the window
        logic value_nan;
        logic last;
    } wes_ctl_t;

endpackage

### rtl/core/windowed_extreme_snap.sv
`timescale 1ns / 1ps

// Windowed extreme snap: takes (depth, value) samples and tracks the sample of greatest
// (mode 1) or least (mode 2) value whose finite depth lies within window_size of the
// clicked depth; a nan value wins over numbers and holds, ties keep the earlier sample.
// On the word marked tlast one result word is produced: the snapped depth with window_hit
// set, or the clicked depth with window_hit clear when nothing fell in the window or
// snapping is off; the running state then clears for the next curve. Throughput is one
// sample per clock unless stalled, set by the compare-and-select loop on the best-so-far
// registers; a word passes the input and result registers. Users must write registers
// through the cfg port only while no curve is in flight; the block does not enforce it.
module windowed_extreme_snap #(
    parameter int DEPTH_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // config write channel
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [wes_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [((DEPTH_BITS > wes_pkg::WIN_W) ? DEPTH_BITS : wes_pkg::WIN_W)-1:0] cfg_data,
    // sample stream
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // sample_depth, sample_value, zero pad
    input  logic [((DEPTH_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // depth_finite, value_nan
    input  logic [1:0]                                  s_axis_tuser,
    input  logic                                        s_axis_tlast,
    // result stream
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // snapped_result, zero pad
    output logic [((DEPTH_BITS + 7) / 8) * 8 - 1:0]     m_axis_tdata,
    // window_hit
    output logic [0:0]                                  m_axis_tuser
);
    import wes_pkg::*;

    localparam int OUT_DATA_W = ((DEPTH_BITS + 7) / 8) * 8;

    // configuration registers
    logic [1:0]                     snap_mode_reg;
    logic signed [DEPTH_BITS-1:0]   click_reg;
    logic [WIN_W-1:0]               window_size_reg;

    // input stage
    logic                           s1_valid_reg, s1_valid_next;
    logic signed [DEPTH_BITS-1:0]   s1_depth_reg;
    logic signed [VALUE_BITS-1:0]   s1_value_reg;
    logic                           s1_finite_reg;
    logic                           s1_nan_reg;
    logic                           s1_last_reg;

    // output stage
    logic                           out_valid_reg, out_valid_next;
    logic signed [DEPTH_BITS-1:0]   out_depth_reg;
    logic                           out_hit_reg;

    logic                           advance;
    logic                           in_window;
    wes_ctl_t                       ctl;
    logic signed [DEPTH_BITS-1:0]   result_depth;
    logic                           result_hit;
    logic                           have_best;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_mode_reg   <= MODE_NONE;
            click_reg       <= '0;
            window_size_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SNAP_MODE:   snap_mode_reg   <= cfg_data[1:0];
                REG_CLICK:       click_reg       <= cfg_data[DEPTH_BITS-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // the whole pipe moves whenever the result register is free
    assign advance        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready  = advance;
    assign s1_valid_next  = advance ? s_axis_tvalid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_axis_tvalid)
        begin
            s1_depth_reg  <= s_axis_tdata[DEPTH_BITS-1:0];
            s1_value_reg  <= s_axis_tdata[DEPTH_BITS+VALUE_BITS-1:DEPTH_BITS];
            s1_finite_reg <= s_axis_tuser[0];
            s1_nan_reg    <= s_axis_tuser[1];
            s1_last_reg   <= s_axis_tlast;
        end
    end

    wes_window #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_window (
        .sample_depth (s1_depth_reg),
        .depth_finite (s1_finite_reg),
        .click_pos    (click_reg),
        .window_size  (window_size_reg),
        .in_window    (in_window)
    );

    always_comb
    begin
        ctl.step      = s1_valid_reg && advance;
        ctl.in_window = in_window;
        ctl.value_nan = s1_nan_reg;
        ctl.last      = s1_last_reg;
    end

    wes_track #(
        .DEPTH_BITS (DEPTH_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .snap_mode    (snap_mode_reg),
        .click_pos    (click_reg),
        .sample_depth (s1_depth_reg),
        .sample_value (s1_value_reg),
        .result_depth (result_depth),
        .result_hit   (result_hit),
        .have_best    (have_best)
    );

    assign out_valid_next = advance ? (ctl.step && ctl.last) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && ctl.last)
        begin
            out_depth_reg <= result_depth;
            out_hit_reg   <= result_hit;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-DEPTH_BITS){1'b0}}, out_depth_reg};
    assign m_axis_tuser  = out_hit_reg;

    // a result word only follows a last sample processed the cycle before
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg && advance))
        else $error("result word without a last sample");

    // a hit needs an active snap mode at the time the result was formed
    a_hit_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_hit_reg |->
            ($past(snap_mode_reg) == MODE_MAX || $past(snap_mode_reg) == MODE_MIN))
        else $error("window hit with snapping off");

    // running best is dropped once a curve ends
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && ctl.last |=> !have_best)
        else $error("best not cleared after last sample");

endmodule

### rtl/core/wes_window.sv
`timescale 1ns / 1ps

module wes_window #(
    parameter int DEPTH_BITS = 32
) (
    input  logic signed [DEPTH_BITS-1:0]    sample_depth,
    input  logic                            depth_finite,
    input  logic signed [DEPTH_BITS-1:0]    click_pos,
    input  logic [wes_pkg::WIN_W-1:0]       window_size,
    output logic                            in_window
);
    import wes_pkg::*;

    // wide enough for the exact difference and for the window register
    localparam int CMP_W = (DEPTH_BITS + 2 > WIN_W + 2) ? DEPTH_BITS + 2 : WIN_W + 2;

    logic signed [CMP_W-1:0] depth_ext;
    logic signed [CMP_W-1:0] click_ext;
    logic signed [CMP_W-1:0] win_ext;
    logic signed [CMP_W-1:0] diff;

    always_comb
    begin
        depth_ext = {{(CMP_W-DEPTH_BITS){sample_depth[DEPTH_BITS-1]}}, sample_depth};
        click_ext = {{(CMP_W-DEPTH_BITS){click_pos[DEPTH_BITS-1]}}, click_pos};
        win_ext   = {{(CMP_W-WIN_W){1'b0}}, window_size};
        diff      = depth_ext - click_ext;
        in_window = depth_finite && (diff <= win_ext) && (diff >= -win_ext);
    end

endmodule

### rtl/core/wes_track.sv
`timescale 1ns / 1ps

module wes_track #(
    parameter int DEPTH_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wes_pkg::wes_ctl_t               ctl,
    input  logic [1:0]                      snap_mode,
    input  logic signed [DEPTH_BITS-1:0]    click_pos,
    input  logic signed [DEPTH_BITS-1:0]    sample_depth,
    input  logic signed [VALUE_BITS-1:0]    sample_value,
    output logic signed [DEPTH_BITS-1:0]    result_depth,
    output logic                            result_hit,
    output logic                            have_best
);
    import wes_pkg::*;

    logic                           have_best_reg, have_best_next;
    logic                           best_nan_reg, best_nan_next;
    logic signed [DEPTH_BITS-1:0]   best_depth_reg, best_depth_next;
    logic signed [VALUE_BITS-1:0]   best_value_reg, best_value_next;

    logic                           active;
    logic                           better;
    logic                           take;
    logic                           have_post;
    logic                           nan_post;
    logic signed [DEPTH_BITS-1:0]   depth_post;
    logic signed [VALUE_BITS-1:0]   value_post;

    always_comb
    begin
        active = (snap_mode == MODE_MAX) || (snap_mode == MODE_MIN);
        better = (snap_mode == MODE_MAX) ? (sample_value > best_value_reg)
                                         : (sample_value < best_value_reg);
        // first sample seeds, first nan wins and holds, ties keep the earlier one
        priority if (!have_best_reg)
            take = 1'b1;
        else if (ctl.value_nan)
            take = !best_nan_reg;
        else
            take = !best_nan_reg && better;

        have_post  = have_best_reg;
        nan_post   = best_nan_reg;
        depth_post = best_depth_reg;
        value_post = best_value_reg;
        if (ctl.step && active && ctl.in_window && take)
        begin
            have_post  = 1'b1;
            nan_post   = ctl.value_nan;
            depth_post = sample_depth;
            value_post = ctl.value_nan ? '0 : sample_value;
        end

        result_hit   = active && have_post;
        result_depth = result_hit ? depth_post : click_pos;

        if (ctl.step && ctl.last)
        begin
            have_best_next  = 1'b0;
            best_nan_next   = 1'b0;
            best_depth_next = '0;
            best_value_next = '0;
        end
        else
        begin
            have_best_next  = have_post;
            best_nan_next   = nan_post;
            best_depth_next = depth_post;
            best_value_next = value_post;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg  <= 1'b0;
            best_nan_reg   <= 1'b0;
            best_depth_reg <= '0;
            best_value_reg <= '0;
        end
        else
        begin
            have_best_reg  <= have_best_next;
            best_nan_reg   <= best_nan_next;
            best_depth_reg <= best_depth_next;
            best_value_reg <= best_value_next;
        end
    end

    assign have_best = have_best_reg;

endmodule
